>>> sv/aarch64_load_store_decoder_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the AArch64 load/store decoder
// Clocked concurrent checks, compiled out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef AARCH64_LOAD_STORE_DECODER_ASSERT_SVH
`define AARCH64_LOAD_STORE_DECODER_ASSERT_SVH

`ifndef SYNTH
// Check a property on every rising edge outside reset.
`define LSD_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("lsd assertion failed: lbl");
// Check a property on every rising edge, reset included.
`define LSD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("lsd assertion failed: lbl");
`else
`define LSD_ASSERT(lbl, clk, rst, prop)
`define LSD_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

>>> sv/lsd_pkg.sv
// ---------------------------------------------------------------------------
// lsd_pkg
// Encodings, stage payload types and constants of the load/store decoder.
// ---------------------------------------------------------------------------
package lsd_pkg;

  localparam logic [31:0] UIMM_MASK  = 32'h3B00_0000;
  localparam logic [31:0] UIMM_MATCH = 32'h3900_0000;
  localparam logic [31:0] IDX_MASK   = 32'h3B20_0000;
  localparam logic [31:0] IDX_MATCH  = 32'h3800_0000;
  localparam logic [31:0] PAIR_MASK  = 32'h3A00_0000;
  localparam logic [31:0] PAIR_MATCH = 32'h2800_0000;

  // Index field codes
  localparam logic [1:0] IDX_NONE   = 2'd0;
  localparam logic [1:0] IDX_POST   = 2'd1;
  localparam logic [1:0] IDX_OFFSET = 2'd2;
  localparam logic [1:0] IDX_PRE    = 2'd3;

  // Size / opc codes
  localparam logic [1:0] SIZE_WORD  = 2'd2;
  localparam logic [1:0] SIZE_DWORD = 2'd3;
  localparam logic [1:0] OPC_STORE  = 2'd0;
  localparam logic [1:0] OPC_SW     = 2'd1;
  localparam logic [1:0] OPC_WIDE   = 2'd2;
  localparam logic [1:0] OPC_RSVD   = 2'd3;

  localparam logic [1:0] SCALE_4 = 2'd2;
  localparam logic [1:0] SCALE_8 = 2'd3;

  localparam logic [4:0] PAIR_BYTES_NARROW = 5'd8;
  localparam logic [4:0] PAIR_BYTES_WIDE   = 5'd16;

  typedef enum logic [1:0] {
    FORM_NONE,
    FORM_UIMM,
    FORM_IDX,
    FORM_PAIR
  } form_t;

  typedef enum logic [1:0] {
    OFF_UIMM12,
    OFF_SIMM9,
    OFF_SIMM7
  } off_kind_t;

  typedef struct packed {
    form_t       form;
    logic [31:0] word;
  } cls_t;

  typedef struct packed {
    logic      ok;
    logic      load;
    logic      pair;
    logic      pre;
    logic      post;
    logic [4:0] rn;
    logic [4:0] rt;
    logic [4:0] bytes;
    off_kind_t kind;
    logic [1:0] scale;
    logic [11:0] imm;
  } dec_t;

  typedef struct packed {
    logic        valid_res;
    logic        is_load;
    logic        is_write;
    logic [4:0]  base_register;
    logic [4:0]  data_register;
    logic [15:0] byte_offset;
    logic [4:0]  access_bytes;
    logic        is_pair;
    logic        wb_before;
    logic        wb_after;
  } res_t;

endpackage

>>> sv/lsd_classify.sv
// ---------------------------------------------------------------------------
// lsd_classify
// Stage one: match the word against the three encoding groups.
// ---------------------------------------------------------------------------
module lsd_classify import lsd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] word,
  output logic        out_valid,
  input  logic        out_ready,
  output cls_t        out_data
);

  form_t form_next;

  // First match wins.
  always_comb begin
    priority if ((word & UIMM_MASK) == UIMM_MATCH) begin
      form_next = FORM_UIMM;
    end else if ((word & IDX_MASK) == IDX_MATCH) begin
      form_next = FORM_IDX;
    end else if ((word & PAIR_MASK) == PAIR_MATCH) begin
      form_next = FORM_PAIR;
    end else begin
      form_next = FORM_NONE;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data.form <= form_next;
      out_data.word <= word;
    end
  end

endmodule

>>> sv/lsd_decode.sv
// ---------------------------------------------------------------------------
// lsd_decode
// Stage two: check allocation per form and pull out flags and raw immediate.
// ---------------------------------------------------------------------------
module lsd_decode import lsd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  cls_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output dec_t out_data
);

  dec_t        dec_next;
  logic [31:0] w;
  logic [1:0]  size;
  logic [1:0]  opc;
  logic [1:0]  idx;
  logic [1:0]  popc;
  logic [1:0]  pidx;
  logic        pload;
  logic        wide;

  assign w     = in_data.word;
  assign size  = w[31:30];
  assign opc   = w[23:22];
  assign idx   = w[11:10];
  assign popc  = w[31:30];
  assign pidx  = w[24:23];
  assign pload = w[22];
  assign wide  = (popc == OPC_WIDE);

  always_comb begin
    dec_next       = '0;
    dec_next.rn    = w[9:5];
    dec_next.rt    = w[4:0];
    dec_next.kind  = OFF_UIMM12;
    unique case (in_data.form)
      FORM_UIMM: begin
        dec_next.ok    = !((size == SIZE_WORD && opc == OPC_RSVD) ||
                           (size == SIZE_DWORD && opc[1]));
        dec_next.load  = (opc != OPC_STORE);
        dec_next.bytes = 5'd1 << size;
        dec_next.scale = size;
        dec_next.imm   = w[21:10];
      end
      FORM_IDX: begin
        dec_next.ok    = (idx != IDX_OFFSET) &&
                         !(size == SIZE_DWORD && opc[1]) &&
                         !(size == SIZE_WORD && opc == OPC_RSVD);
        dec_next.load  = (opc != OPC_STORE);
        dec_next.bytes = 5'd1 << size;
        dec_next.kind  = OFF_SIMM9;
        dec_next.imm   = {3'b000, w[20:12]};
        dec_next.pre   = (idx == IDX_PRE);
        dec_next.post  = (idx == IDX_POST);
      end
      FORM_PAIR: begin
        // Reserved opc and the tagged store pair are rejected.
        dec_next.ok    = (popc != OPC_RSVD) &&
                         !(popc == OPC_SW && pidx == IDX_OFFSET && !pload);
        dec_next.load  = pload;
        dec_next.pair  = 1'b1;
        dec_next.bytes = wide ? PAIR_BYTES_WIDE : PAIR_BYTES_NARROW;
        dec_next.kind  = OFF_SIMM7;
        dec_next.scale = wide ? SCALE_8 : SCALE_4;
        dec_next.imm   = {5'b00000, w[21:15]};
        dec_next.pre   = (pidx == IDX_PRE);
        dec_next.post  = (pidx == IDX_POST);
      end
      default: begin
        dec_next.ok = 1'b0;
      end
    endcase
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= dec_next;
    end
  end

endmodule

>>> sv/lsd_pack.sv
// ---------------------------------------------------------------------------
// lsd_pack
// Stage three: scale and extend the offset, zero rejected words, hold result.
// ---------------------------------------------------------------------------
module lsd_pack import lsd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  dec_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_data
);

  res_t        res_next;
  logic [15:0] off;

  always_comb begin
    unique case (in_data.kind)
      OFF_UIMM12: off = {4'b0000, in_data.imm} << in_data.scale;
      OFF_SIMM9:  off = {{7{in_data.imm[8]}}, in_data.imm[8:0]};
      OFF_SIMM7:  off = {{9{in_data.imm[6]}}, in_data.imm[6:0]} << in_data.scale;
      default:    off = '0;
    endcase
  end

  always_comb begin
    res_next = '0;
    if (in_data.ok) begin
      res_next.valid_res     = 1'b1;
      res_next.is_load       = in_data.load;
      res_next.is_write      = !in_data.load;
      res_next.base_register = in_data.rn;
      res_next.data_register = in_data.rt;
      res_next.byte_offset   = off;
      res_next.access_bytes  = in_data.bytes;
      res_next.is_pair       = in_data.pair;
      res_next.wb_before     = in_data.pre;
      res_next.wb_after      = in_data.post;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= res_next;
    end
  end

endmodule

>>> sv/aarch64_load_store_decoder.sv
// A word passes the classify, decode and pack registers before it is offered.
// Throughput: one instruction word per cycle when out_stall is low; the three
// register stages (classify, decode, pack) each take a new word whenever the
// stage ahead moves. A stalled result holds in the pack stage while earlier
// stages keep filling. Reset (rst, synchronous, active high) clears the stage
// valid bits only.
// ---------------------------------------------------------------------------
// aarch64_load_store_decoder
// Three-stage pipelined classifier of AArch64 load/store instruction words.
// ---------------------------------------------------------------------------
`include "aarch64_load_store_decoder_assert.svh"

module aarch64_load_store_decoder import lsd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // instruction channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        instruction,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic               valid_res,
  output logic               is_load,
  output logic               is_write,
  output logic [4:0]         base_register,
  output logic [4:0]         data_register,
  output logic signed [15:0] byte_offset,
  output logic [4:0]         access_bytes,
  output logic               is_pair,
  output logic               wb_before,
  output logic               wb_after
);

  // Inter-stage handshake: valid flows forward, ready flows back.
  logic in_ready;
  logic cls_valid;
  logic cls_ready;
  cls_t cls_data;
  logic dec_valid;
  logic dec_ready;
  dec_t dec_data;
  res_t res;
  // Helpers for the checks at the end of the module.
  logic res_zero;
  logic width_ok;

  assign in_stall = !in_ready;

  // Stage one: pick the encoding group of the word.
  lsd_classify u_classify (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .word      (instruction),
    .out_valid (cls_valid),
    .out_ready (cls_ready),
    .out_data  (cls_data)
  );

  // Stage two: reject unallocated forms, extract flags and the raw immediate.
  lsd_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cls_valid),
    .in_ready  (cls_ready),
    .in_data   (cls_data),
    .out_valid (dec_valid),
    .out_ready (dec_ready),
    .out_data  (dec_data)
  );

  // Stage three: build the byte offset and hold the result for transfer.
  lsd_pack u_pack (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dec_valid),
    .in_ready  (dec_ready),
    .in_data   (dec_data),
    .out_valid (out_valid),
    .out_ready (!out_stall),
    .out_data  (res)
  );

  // Drive the result ports straight from the output register.
  assign valid_res     = res.valid_res;
  assign is_load       = res.is_load;
  assign is_write      = res.is_write;
  assign base_register = res.base_register;
  assign data_register = res.data_register;
  assign byte_offset   = $signed(res.byte_offset);
  assign access_bytes  = res.access_bytes;
  assign is_pair       = res.is_pair;
  assign wb_before     = res.wb_before;
  assign wb_after      = res.wb_after;

  assign res_zero = (res == '0);
  assign width_ok = is_pair ? (access_bytes == PAIR_BYTES_NARROW ||
                               access_bytes == PAIR_BYTES_WIDE) :
                              (access_bytes == 5'd1 || access_bytes == 5'd2 ||
                               access_bytes == 5'd4 || access_bytes == 5'd8);

  // A rejected word must leave every field zero.
  `LSD_ASSERT(a_invalid_zero, clk, rst, (out_valid && !valid_res) |-> res_zero)
  // A recognized access is exactly one of load or store.
  `LSD_ASSERT(a_load_xor_store, clk, rst, (out_valid && valid_res) |-> (is_load != is_write))
  // Pre- and post-index writeback never coexist.
  `LSD_ASSERT(a_index_excl, clk, rst, out_valid |-> !(wb_before && wb_after))
  // Access width matches the form.
  `LSD_ASSERT(a_width_form, clk, rst, (out_valid && valid_res) |-> width_ok)
  // Pipeline is empty in the cycle after reset.
  `LSD_ASSERT_ALWAYS(a_reset_empty, clk, $past(rst) |-> (!out_valid && !cls_valid && !dec_valid))

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Drives AArch64 instruction words into the load/store decoder and checks
// every decoded result against a behavioral decode kept in this bench.
// ---------------------------------------------------------------------------
module testbench import lsd_pkg::*;;

  // Cycles without any transfer before the run is declared hung. The long
  // receiver hold below is well inside this.
  localparam int STUCK_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int REPORT_MAX = 10;
  // Outstanding words never exceed the pipeline depth; keep some headroom.
  localparam int PEND_DEPTH = 16;

  // One outstanding decode: the word that went in and what must come out.
  typedef struct packed {
    logic [31:0] word;
    res_t        res;
  } pending_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] instruction = '0;

  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               valid_res;
  logic               is_load;
  logic               is_write;
  logic [4:0]         base_register;
  logic [4:0]         data_register;
  logic signed [15:0] byte_offset;
  logic [4:0]         access_bytes;
  logic               is_pair;
  logic               wb_before;
  logic               wb_after;

  // Ring of expected decodes, written at input transfers and read in order
  // at result transfers.
  pending_t pending_ring [PEND_DEPTH];
  int       taken_count = 0;
  int       checked_count = 0;
  pending_t oldest;
  res_t     decoded;
  int       mismatches = 0;
  int       stuck_cycles = 0;

  // Idle controls. send_gaps belongs to the stimulus process only; the other
  // two are read by the receiver process and are written with nonblocking
  // assignments so the handoff is race free.
  bit send_gaps = 1'b1;
  bit recv_gaps = 1'b1;
  bit long_hold = 1'b0;

  always #5 clk = ~clk;

  aarch64_load_store_decoder uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .instruction   (instruction),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .valid_res     (valid_res),
    .is_load       (is_load),
    .is_write      (is_write),
    .base_register (base_register),
    .data_register (data_register),
    .byte_offset   (byte_offset),
    .access_bytes  (access_bytes),
    .is_pair       (is_pair),
    .wb_before     (wb_before),
    .wb_after      (wb_after)
  );

  // -------------------------------------------------------------------------
  // Behavioral decode. The three encodings are tried in priority order and
  // the first mask/match hit decides. The vector bit (26) is in no mask, so
  // SIMD forms decode exactly like the general register forms.
  // -------------------------------------------------------------------------
  function automatic res_t decode_access(logic [31:0] w);
    res_t        r;
    form_t       form;
    logic [1:0]  size;
    logic [1:0]  opc;
    logic [1:0]  idx;
    logic [15:0] simm;
    r = '0;
    size = w[31:30];
    if ((w & UIMM_MASK) == UIMM_MATCH) form = FORM_UIMM;
    else if ((w & IDX_MASK) == IDX_MATCH) form = FORM_IDX;
    else if ((w & PAIR_MASK) == PAIR_MATCH) form = FORM_PAIR;
    else form = FORM_NONE;
    case (form)
      FORM_UIMM: begin
        // Prefetch and the unallocated opc values of the wide sizes drop out.
        opc = w[23:22];
        if (!((size == SIZE_WORD && opc == OPC_RSVD) ||
              (size == SIZE_DWORD && opc >= OPC_WIDE))) begin
          r.valid_res    = 1'b1;
          r.is_load      = (opc != OPC_STORE);
          r.byte_offset  = {4'd0, w[21:10]} << size;
          r.access_bytes = 5'd1 << size;
        end
      end
      FORM_IDX: begin
        // Unprivileged accesses are rejected along with the same opc holes.
        opc = w[23:22];
        idx = w[11:10];
        if (idx != IDX_OFFSET && !(size == SIZE_DWORD && opc >= OPC_WIDE) &&
            !(size == SIZE_WORD && opc == OPC_RSVD)) begin
          r.valid_res    = 1'b1;
          r.is_load      = (opc != OPC_STORE);
          r.byte_offset  = {{7{w[20]}}, w[20:12]};
          r.access_bytes = 5'd1 << size;
          r.wb_before    = (idx == IDX_PRE);
          r.wb_after     = (idx == IDX_POST);
        end
      end
      FORM_PAIR: begin
        // Reserved opc and the tagged store pair are rejected; non-temporal
        // pairs pass with neither index flag set.
        opc = w[31:30];
        idx = w[24:23];
        if (opc != OPC_RSVD && !(opc == OPC_SW && idx == IDX_OFFSET && !w[22])) begin
          simm = {{9{w[21]}}, w[21:15]};
          r.valid_res = 1'b1;
          r.is_load   = w[22];
          r.is_pair   = 1'b1;
          r.wb_before = (idx == IDX_PRE);
          r.wb_after  = (idx == IDX_POST);
          if (opc == OPC_WIDE) begin
            r.byte_offset  = simm << SCALE_8;
            r.access_bytes = PAIR_BYTES_WIDE;
          end else begin
            r.byte_offset  = simm << SCALE_4;
            r.access_bytes = PAIR_BYTES_NARROW;
          end
        end
      end
      default: ;
    endcase
    if (r.valid_res) begin
      r.is_write      = !r.is_load;
      r.base_register = w[9:5];
      r.data_register = w[4:0];
    end
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // Encoders for the three forms. Fixed bits come from the match constants;
  // every other bit is a field.
  // -------------------------------------------------------------------------
  function automatic logic [31:0] enc_uimm(logic [1:0] size, logic vec, logic [1:0] opc,
                                           logic [11:0] imm, logic [4:0] rn, logic [4:0] rt);
    logic [31:0] w;
    w = UIMM_MATCH;
    w[31:30] = size;
    w[26]    = vec;
    w[23:22] = opc;
    w[21:10] = imm;
    w[9:5]   = rn;
    w[4:0]   = rt;
    return w;
  endfunction

  function automatic logic [31:0] enc_idx(logic [1:0] size, logic vec, logic [1:0] opc,
                                          logic [8:0] imm, logic [1:0] idx, logic [4:0] rn,
                                          logic [4:0] rt);
    logic [31:0] w;
    w = IDX_MATCH;
    w[31:30] = size;
    w[26]    = vec;
    w[23:22] = opc;
    w[20:12] = imm;
    w[11:10] = idx;
    w[9:5]   = rn;
    w[4:0]   = rt;
    return w;
  endfunction

  function automatic logic [31:0] enc_pair(logic [1:0] opc, logic vec, logic [1:0] idx,
                                           logic ld, logic [6:0] imm, logic [4:0] rt2,
                                           logic [4:0] rn, logic [4:0] rt);
    logic [31:0] w;
    w = PAIR_MATCH;
    w[31:30] = opc;
    w[26]    = vec;
    w[24:23] = idx;
    w[22]    = ld;
    w[21:15] = imm;
    w[14:10] = rt2;
    w[9:5]   = rn;
    w[4:0]   = rt;
    return w;
  endfunction

  // Mostly well-formed memory accesses with random fields; the rest is raw
  // noise, which also toggles every bit of the word.
  function automatic logic [31:0] random_access_word();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30)
      return enc_uimm(2'($urandom), 1'($urandom), 2'($urandom), 12'($urandom),
                      5'($urandom), 5'($urandom));
    else if (pick < 60)
      return enc_idx(2'($urandom), 1'($urandom), 2'($urandom), 9'($urandom),
                     2'($urandom), 5'($urandom), 5'($urandom));
    else if (pick < 85)
      return enc_pair(2'($urandom), 1'($urandom), 2'($urandom), 1'($urandom),
                      7'($urandom), 5'($urandom), 5'($urandom), 5'($urandom));
    else
      return $urandom;
  endfunction

  // -------------------------------------------------------------------------
  // Send one word. Optionally drop valid for a short burst first, then hold
  // the word until the decoder takes it. Valid is left high on return so
  // back-to-back words stream without a bubble.
  // -------------------------------------------------------------------------
  task automatic send_word(input logic [31:0] w);
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    instruction <= w;
    do @(posedge clk); while (in_stall);
  endtask

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------
  task automatic test_directed();
    // unsigned offset: largest scaled offset, zero byte store, sign-extending
    // load, prefetch and the unallocated wide opc values, a SIMD load
    send_word(enc_uimm(SIZE_DWORD, 1'b0, 2'd1, 12'hFFF, 5'd31, 5'd31));
    send_word(enc_uimm(2'd0, 1'b0, OPC_STORE, 12'h000, 5'd0, 5'd0));
    send_word(enc_uimm(2'd1, 1'b0, OPC_WIDE, 12'h800, 5'd5, 5'd7));
    send_word(enc_uimm(SIZE_DWORD, 1'b0, OPC_WIDE, 12'h123, 5'd1, 5'd2));
    send_word(enc_uimm(SIZE_DWORD, 1'b0, OPC_RSVD, 12'h321, 5'd3, 5'd4));
    send_word(enc_uimm(SIZE_WORD, 1'b0, OPC_RSVD, 12'h0F0, 5'd9, 5'd10));
    send_word(enc_uimm(SIZE_WORD, 1'b1, OPC_WIDE, 12'h00F, 5'd17, 5'd18));
    // unscaled / indexed: both imm9 extremes, every index mode, the
    // unprivileged form and the opc holes
    send_word(enc_idx(SIZE_DWORD, 1'b0, 2'd1, 9'h100, IDX_PRE, 5'd31, 5'd0));
    send_word(enc_idx(2'd0, 1'b0, OPC_STORE, 9'h0FF, IDX_POST, 5'd0, 5'd31));
    send_word(enc_idx(2'd1, 1'b0, OPC_WIDE, 9'h1FF, IDX_NONE, 5'd12, 5'd13));
    send_word(enc_idx(SIZE_WORD, 1'b0, 2'd1, 9'h010, IDX_OFFSET, 5'd14, 5'd15));
    send_word(enc_idx(SIZE_DWORD, 1'b0, OPC_WIDE, 9'h020, IDX_NONE, 5'd16, 5'd17));
    send_word(enc_idx(SIZE_WORD, 1'b0, OPC_RSVD, 9'h030, IDX_POST, 5'd18, 5'd19));
    // pairs: non-temporal, wide pre and post with imm7 extremes, tagged
    // store pair against its load twin, reserved opc, plain offset
    send_word(enc_pair(OPC_STORE, 1'b0, IDX_NONE, 1'b0, 7'h40, 5'd3, 5'd20, 5'd21));
    send_word(enc_pair(OPC_WIDE, 1'b0, IDX_PRE, 1'b1, 7'h3F, 5'd3, 5'd22, 5'd23));
    send_word(enc_pair(OPC_WIDE, 1'b1, IDX_POST, 1'b0, 7'h40, 5'd3, 5'd24, 5'd25));
    send_word(enc_pair(OPC_SW, 1'b0, IDX_OFFSET, 1'b0, 7'h05, 5'd3, 5'd26, 5'd27));
    send_word(enc_pair(OPC_SW, 1'b0, IDX_OFFSET, 1'b1, 7'h05, 5'd3, 5'd26, 5'd27));
    send_word(enc_pair(OPC_RSVD, 1'b0, IDX_OFFSET, 1'b1, 7'h01, 5'd3, 5'd28, 5'd29));
    send_word(enc_pair(OPC_STORE, 1'b0, IDX_OFFSET, 1'b0, 7'h01, 5'd3, 5'd30, 5'd1));
    // no match: all zeros, all ones, literal load, register offset form
    send_word(32'h0000_0000);
    send_word(32'hFFFF_FFFF);
    send_word(32'h1800_0000);
    send_word(32'h3820_0000);
  endtask

  task automatic test_random(input int count);
    repeat (count) send_word(random_access_word());
  endtask

  // Freeze the result side for a long stretch while words keep coming, so
  // the pipeline fills and the input stall has to assert and release.
  task automatic test_backpressure(input int count);
    send_gaps = 1'b0;
    long_hold <= 1'b1;
    repeat (count) send_word(random_access_word());
    send_gaps = 1'b1;
  endtask

  // Closing stretch at full rate on both sides.
  task automatic test_streaming(input int count);
    send_gaps = 1'b0;
    recv_gaps <= 1'b0;
    repeat (count) send_word(random_access_word());
  endtask

  // -------------------------------------------------------------------------
  // Sequence
  // -------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(500);
    test_backpressure(60);
    test_random(500);
    test_streaming(200);
    in_valid <= 1'b0;
    // Drain; the watchdog catches a result that never shows up.
    while (taken_count != checked_count) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && taken_count == checked_count) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // -------------------------------------------------------------------------
  // Receiver: random stall bursts, or one long hold on request.
  // -------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold) begin
        long_hold <= 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (recv_gaps && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Record the expected decode of every word the block takes.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      pending_ring[4'(taken_count)] <= '{word: instruction, res: decode_access(instruction)};
      taken_count <= taken_count + 1;
    end
  end

  // -------------------------------------------------------------------------
  // Check every result transfer against the oldest outstanding decode.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      decoded = {valid_res, is_load, is_write, base_register, data_register, byte_offset,
                 access_bytes, is_pair, wb_before, wb_after};
      if (checked_count == taken_count) begin
        if (mismatches < REPORT_MAX)
          $display("%0t: result with nothing outstanding", $realtime);
        mismatches++;
      end else begin
        oldest = pending_ring[4'(checked_count)];
        checked_count <= checked_count + 1;
        if (decoded !== oldest.res) begin
          if (mismatches < REPORT_MAX) begin
            $display("%0t: mismatch for word %h", $realtime, oldest.word);
            $display("  expected v%0b ld%0b st%0b rn %0d rt %0d off %0d",
                     oldest.res.valid_res, oldest.res.is_load, oldest.res.is_write,
                     oldest.res.base_register, oldest.res.data_register,
                     $signed(oldest.res.byte_offset));
            $display("           bytes %0d pair%0b pre%0b post%0b",
                     oldest.res.access_bytes, oldest.res.is_pair,
                     oldest.res.wb_before, oldest.res.wb_after);
            $display("  actual   v%0b ld%0b st%0b rn %0d rt %0d off %0d",
                     valid_res, is_load, is_write, base_register, data_register,
                     byte_offset);
            $display("           bytes %0d pair%0b pre%0b post%0b",
                     access_bytes, is_pair, wb_before, wb_after);
          end
          mismatches++;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Watchdog: advance only while no transfer happens on either side, and end the run at the limit.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

endmodule

>>> aarch64_load_store_decoder.f
+incdir+sv
sv/lsd_pkg.sv
sv/lsd_classify.sv
sv/lsd_decode.sv
sv/lsd_pack.sv
sv/aarch64_load_store_decoder.sv
sim/testbench.sv
